// ===== rtl/text_console_cursor_engine_defines.svh =====
// Assertion macros shared by the text console cursor engine modules.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TCC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TCC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tcc_pkg.sv =====
// Package of types, codes and constants for the text console cursor engine.
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS    = 25;

   localparam int MODE_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int NCOL_W   = 7;
   localparam int NROW_W   = 5;
   localparam int CIDX_W   = 11;
   localparam int CELL_W   = 16;
   localparam int COLOR_W  = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [CHAR_W-1:0]  CH_CR       = 8'd13;
   localparam logic [CHAR_W-1:0]  CH_LF       = 8'd10;
   localparam logic [CHAR_W-1:0]  CH_TAB      = 8'd9;
   localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;
   localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd7;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUT    = 2'd0,
      MODE_CURSOR = 2'd1,
      MODE_READ   = 2'd2,
      MODE_CLEAR  = 2'd3
   } tcc_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHAR_COLOR  = 1'b0,
      CSR_BLANK_COLOR = 1'b1
   } tcc_csr_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CHAR,
      WR_COPY,
      WR_BLANK,
      WR_RESET
   } tcc_wr_sel_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_SET,
      CUR_ADVANCE,
      CUR_NEWLINE,
      CUR_HOME
   } tcc_cur_op_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_PUT,
      ST_NEWLINE,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_FILL,
      ST_CLEAR,
      ST_READ,
      ST_DONE
   } tcc_state_type;

   typedef struct packed {
      logic           capture;
      logic           tab_load;
      logic           tab_dec;
      tcc_wr_sel_type wr_sel;
      logic           rd_cell;
      logic           rd_scroll;
      logic           walk_clr;
      logic           walk_inc;
      tcc_cur_op_type cur_op;
      logic           mark_scroll;
      logic           data_load;
      logic           rsp_load;
   } tcc_cmd_type;

   typedef struct packed {
      tcc_mode_type mode;
      logic         is_cr;
      logic         is_lf;
      logic         col_last;
      logic         line_last;
      logic         tab_last;
      logic         tab_more;
      logic         copy_last;
      logic         fill_last;
   } tcc_status_type;

endpackage

`default_nettype wire

// ===== rtl/tcc_datapath.sv =====
// Datapath of the text console cursor engine: cell memory, cursor, walk counter, result.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_cursor_engine_defines.svh"

module tcc_datapath #(
   parameter int COLUMNS = tcc_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tcc_pkg::DEFAULT_ROWS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [tcc_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [tcc_pkg::CHAR_W-1:0]    req_char_byte,
   input  wire logic [tcc_pkg::NCOL_W-1:0]    req_new_column,
   input  wire logic [tcc_pkg::NROW_W-1:0]    req_new_row,
   input  wire logic [tcc_pkg::CIDX_W-1:0]    req_cell_index,
   input  wire logic                          csr_write,
   input  wire logic [tcc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tcc_pkg::COLOR_W-1:0]   csr_data,
   input  wire tcc_pkg::tcc_cmd_type          cmd,
   output tcc_pkg::tcc_status_type            status,
   output logic [tcc_pkg::CELL_W-1:0]         rsp_cell_data,
   output logic [tcc_pkg::NCOL_W-1:0]         rsp_cursor_column,
   output logic [tcc_pkg::NROW_W-1:0]         rsp_cursor_row,
   output logic                               rsp_scrolled
);
   import tcc_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);

   logic [CELL_W-1:0] cell_mem [CELL_COUNT];

   tcc_mode_type      mode_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [NCOL_W-1:0] ncol_ff;
   logic [NROW_W-1:0] nrow_ff;
   logic [CIDX_W-1:0] cidx_ff;

   logic [COLOR_W-1:0] char_color_ff, char_color_in;
   logic [COLOR_W-1:0] blank_color_ff, blank_color_in;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  line_ff, line_in;
   logic [ADDR_W-1:0] walk_ff, walk_in;
   logic [1:0]        tab_ff, tab_in;
   logic              scroll_ff, scroll_in;
   logic [CELL_W-1:0] data_ff, data_in;
   logic [CELL_W-1:0] rd_data_ff;

   logic [CELL_W-1:0] rsp_data_ff;
   logic [NCOL_W-1:0] rsp_col_ff;
   logic [NROW_W-1:0] rsp_row_ff;
   logic              rsp_scroll_ff;

   logic [CHAR_W-1:0] put_char;
   logic [ADDR_W-1:0] put_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              wr_en;
   logic              in_range;

   assign put_char = (char_ff == CH_TAB) ? CH_SPACE : char_ff;
   assign put_addr = ADDR_W'(ADDR_W'(line_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff));
   assign in_range = int'(cidx_ff) < CELL_COUNT;

   assign status.mode      = mode_ff;
   assign status.is_cr     = char_ff == CH_CR;
   assign status.is_lf     = char_ff == CH_LF;
   assign status.col_last  = col_ff == COL_W'(COLUMNS - 1);
   assign status.line_last = line_ff == ROW_W'(ROWS - 1);
   assign status.tab_last  = tab_ff == 2'd1;
   assign status.tab_more  = tab_ff != 2'd0;
   assign status.copy_last = walk_ff == ADDR_W'(CELL_COUNT - COLUMNS - 1);
   assign status.fill_last = walk_ff == ADDR_W'(CELL_COUNT - 1);

   // memory port selection
   always_comb begin
      rd_en   = cmd.rd_cell || cmd.rd_scroll;
      rd_addr = cmd.rd_cell ? ADDR_W'(cidx_ff) : ADDR_W'(walk_ff + ADDR_W'(COLUMNS));
      wr_en   = cmd.wr_sel != WR_NONE;
      wr_addr = walk_ff;
      wr_data = {RESET_COLOR, CH_SPACE};
      case (cmd.wr_sel)
         WR_CHAR: begin
            wr_addr = put_addr;
            wr_data = {char_color_ff, put_char};
         end
         WR_COPY:  wr_data = rd_data_ff;
         WR_BLANK: wr_data = {blank_color_ff, CH_SPACE};
         WR_RESET: wr_data = {RESET_COLOR, CH_SPACE};
         default:  wr_data = {RESET_COLOR, CH_SPACE};
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cell_mem[rd_addr];
      end
   end

   always_comb begin
      char_color_in  = char_color_ff;
      blank_color_in = blank_color_ff;
      if (csr_write) begin
         case (tcc_csr_type'(csr_index))
            CSR_CHAR_COLOR:  char_color_in  = csr_data;
            CSR_BLANK_COLOR: blank_color_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      case (cmd.cur_op)
         CUR_SET: begin
            col_in  = (8'(ncol_ff) > 8'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : COL_W'(ncol_ff);
            line_in = (7'(nrow_ff) > 7'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(nrow_ff);
         end
         CUR_ADVANCE: col_in = COL_W'(col_ff + 1'b1);
         CUR_NEWLINE: begin
            col_in = '0;
            if (!status.line_last) begin
               line_in = ROW_W'(line_ff + 1'b1);
            end
         end
         CUR_HOME: begin
            col_in  = '0;
            line_in = '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      walk_in = walk_ff;
      if (cmd.walk_clr) begin
         walk_in = '0;
      end else if (cmd.walk_inc) begin
         walk_in = ADDR_W'(walk_ff + 1'b1);
      end

      tab_in = tab_ff;
      if (cmd.tab_load) begin
         tab_in = (char_ff == CH_TAB) ? 2'd3 : ((char_ff == CH_LF) ? 2'd0 : 2'd1);
      end else if (cmd.tab_dec) begin
         tab_in = tab_ff - 2'd1;
      end

      scroll_in = scroll_ff;
      data_in   = data_ff;
      if (cmd.capture) begin
         scroll_in = 1'b0;
         data_in   = '0;
      end else begin
         if (cmd.mark_scroll) begin
            scroll_in = 1'b1;
         end
         if (cmd.data_load) begin
            data_in = in_range ? rd_data_ff : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_color_ff  <= RESET_COLOR;
         blank_color_ff <= RESET_COLOR;
         col_ff         <= '0;
         line_ff        <= '0;
         walk_ff        <= '0;
         tab_ff         <= '0;
      end else begin
         char_color_ff  <= char_color_in;
         blank_color_ff <= blank_color_in;
         col_ff         <= col_in;
         line_ff        <= line_in;
         walk_ff        <= walk_in;
         tab_ff         <= tab_in;
      end
   end

   always_ff @(posedge clock) begin
      scroll_ff <= scroll_in;
      data_ff   <= data_in;
      if (cmd.capture) begin
         mode_ff <= tcc_mode_type'(req_mode);
         char_ff <= req_char_byte;
         ncol_ff <= req_new_column;
         nrow_ff <= req_new_row;
         cidx_ff <= req_cell_index;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff   <= data_ff;
         rsp_col_ff    <= NCOL_W'(col_ff);
         rsp_row_ff    <= NROW_W'(line_ff);
         rsp_scroll_ff <= scroll_ff;
      end
   end

   assign rsp_cell_data     = rsp_data_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_scrolled      = rsp_scroll_ff;

   `TCC_ASSERT_IMP(a_cursor_in_grid, 1'b1, (int'(col_ff) < COLUMNS) && (int'(line_ff) < ROWS), "cursor left the grid")
   `TCC_ASSERT_IMP(a_copy_after_read, cmd.wr_sel == WR_COPY, $past(cmd.rd_scroll), "scroll copy without a read")
   `TCC_ASSERT_IMP(a_no_read_write_mix, cmd.rd_cell, cmd.wr_sel == WR_NONE, "cell read overlaps a write")

endmodule

`default_nettype wire

// ===== rtl/tcc_controller.sv =====
// Controller state machine of the text console cursor engine.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_cursor_engine_defines.svh"

module tcc_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire tcc_pkg::tcc_status_type status,
   output tcc_pkg::tcc_cmd_type         cmd
);
   import tcc_pkg::*;

   tcc_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.wr_sel = WR_NONE;
      cmd.cur_op = CUR_HOLD;

      case (state_ff)
         ST_INIT: begin
            cmd.wr_sel   = WR_RESET;
            cmd.walk_inc = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.mode)
               MODE_PUT: begin
                  cmd.tab_load = 1'b1;
                  if (status.is_cr) begin
                     state_in = ST_DONE;
                  end else if (status.is_lf) begin
                     state_in = ST_NEWLINE;
                  end else begin
                     state_in = ST_PUT;
                  end
               end
               MODE_CURSOR: begin
                  cmd.cur_op = CUR_SET;
                  state_in   = ST_DONE;
               end
               MODE_READ: begin
                  cmd.rd_cell = 1'b1;
                  state_in    = ST_READ;
               end
               MODE_CLEAR: begin
                  cmd.walk_clr = 1'b1;
                  state_in     = ST_CLEAR;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_PUT: begin
            cmd.wr_sel  = WR_CHAR;
            cmd.tab_dec = 1'b1;
            if (status.col_last) begin
               state_in = ST_NEWLINE;
            end else begin
               cmd.cur_op = CUR_ADVANCE;
               state_in   = status.tab_last ? ST_DONE : ST_PUT;
            end
         end
         ST_NEWLINE: begin
            cmd.cur_op = CUR_NEWLINE;
            if (status.line_last) begin
               cmd.mark_scroll = 1'b1;
               cmd.walk_clr    = 1'b1;
               state_in        = ST_SCROLL_RD;
            end else begin
               state_in = status.tab_more ? ST_PUT : ST_DONE;
            end
         end
         ST_SCROLL_RD: begin
            cmd.rd_scroll = 1'b1;
            state_in      = ST_SCROLL_WR;
         end
         ST_SCROLL_WR: begin
            cmd.wr_sel   = WR_COPY;
            cmd.walk_inc = 1'b1;
            state_in     = status.copy_last ? ST_FILL : ST_SCROLL_RD;
         end
         ST_FILL: begin
            cmd.wr_sel   = WR_BLANK;
            cmd.walk_inc = 1'b1;
            if (status.fill_last) begin
               state_in = status.tab_more ? ST_PUT : ST_DONE;
            end
         end
         ST_CLEAR: begin
            cmd.wr_sel   = WR_BLANK;
            cmd.walk_inc = 1'b1;
            if (status.fill_last) begin
               cmd.cur_op = CUR_HOME;
               state_in   = ST_DONE;
            end
         end
         ST_READ: begin
            cmd.data_load = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = state_ff != ST_IDLE;

   `TCC_ASSERT_NXT(a_accept_decodes, req_valid && !req_stall, state_ff == ST_DECODE, "accepted item not decoded")
   `TCC_ASSERT_NXT(a_no_phantom_rsp, rsp_valid_ff && !rsp_stall && state_ff != ST_DONE, !rsp_valid_ff, "result appeared without an item")
   `TCC_ASSERT_IMP(a_no_overwrite, cmd.rsp_load, !rsp_valid_ff || !rsp_stall, "result overwritten while stalled")

endmodule

`default_nettype wire

// ===== rtl/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// req_     | in        | req_valid/req_stall  | mode, char_byte, new_column, new_row,
//          |           |                      | cell_index
// rsp_     | out       | rsp_valid/rsp_stall  | cell_data, cursor_column, cursor_row,
//          |           |                      | scrolled
// csr_     | in        | csr_write            | csr_index, csr_data
//
// One item at a time: put, newline and read go through accept, decode, work and result;
// set cursor and carriage return skip work; a tab repeats put per extra space, a wrap
// adds a newline step. A scroll copies each cell up a row, reading it then writing it,
// and then blanks the bottom row; a clear blanks every cell of the memory.
// After reset a clearing pass blanks the memory under req_stall.
// A result waits under rsp_stall while the next item is accepted; csr writes are always taken.
module text_console_cursor_engine #(
   parameter int COLUMNS = tcc_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tcc_pkg::DEFAULT_ROWS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tcc_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [tcc_pkg::CHAR_W-1:0]    req_char_byte,
   input  wire logic [tcc_pkg::NCOL_W-1:0]    req_new_column,
   input  wire logic [tcc_pkg::NROW_W-1:0]    req_new_row,
   input  wire logic [tcc_pkg::CIDX_W-1:0]    req_cell_index,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [tcc_pkg::CELL_W-1:0]         rsp_cell_data,
   output logic [tcc_pkg::NCOL_W-1:0]         rsp_cursor_column,
   output logic [tcc_pkg::NROW_W-1:0]         rsp_cursor_row,
   output logic                               rsp_scrolled,
   input  wire logic                          csr_write,
   input  wire logic [tcc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tcc_pkg::COLOR_W-1:0]   csr_data
);
   import tcc_pkg::*;

   // command and status between the state machine and the datapath
   tcc_cmd_type    cmd;
   tcc_status_type status;

   // sequence each item: decode, put/newline/scroll/clear/read, then load the result
   tcc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the cell memory, cursor, colors, walk counter and result register
   tcc_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_mode),
      .req_char_byte     (req_char_byte),
      .req_new_column    (req_new_column),
      .req_new_row       (req_new_row),
      .req_cell_index    (req_cell_index),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_cell_data     (rsp_cell_data),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_scrolled      (rsp_scrolled)
   );

endmodule

`default_nettype wire
